### rtl/stsyn_pkg.sv
// Shared constants, request codes and the sine lookup function for the tone synthesizer.
package stsyn_pkg;

    // Field widths
    localparam int FREQ_W    = 16;
    localparam int LEVEL_W   = 16;
    localparam int REQ_W     = 2;
    localparam int PHASE_W   = 32;
    localparam int AMP_W     = 13;
    localparam int DENS_W    = 8;
    localparam int S_TDATA_W = FREQ_W + LEVEL_W;
    localparam int M_TDATA_W = DENS_W;

    // Arithmetic constants
    localparam int                DEF_FS_HZ   = 32000;
    localparam logic [AMP_W-1:0]  AMP_MAX     = 13'd4096;
    localparam int                AMP_SHIFT   = 12;
    localparam int                INDEX_SHIFT = 24;

    // Sine table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = 8;

    // Request codes carried on tuser
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_OFF  = 2'd2;

    // First quarter of the wave plus the peak; the rest follows by symmetry
    localparam logic [6:0] QUARTER_WAVE [0:64] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,
        7'd24,  7'd27,  7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,
        7'd48,  7'd51,  7'd54,  7'd57,  7'd59,  7'd62,  7'd65,  7'd67,
        7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd82,  7'd85,  7'd87,
        7'd89,  7'd91,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd103,
        7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116,
        7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123,
        7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
        7'd127
    };

    // Signed table entry: mirrored within each half, negated in the upper half
    function automatic logic signed [7:0] sine_value(input logic [TABLE_AW-1:0] idx);
        logic [6:0] k;
        logic [6:0] mag;
        logic [7:0] mirror;
        k      = idx[6:0];
        mirror = 8'd128 - {1'b0, k};
        if (k <= 7'd64) begin
            mag = QUARTER_WAVE[k];
        end else begin
            mag = QUARTER_WAVE[mirror[6:0]];
        end
        if (idx[7]) begin
            return -$signed({1'b0, mag});
        end else begin
            return $signed({1'b0, mag});
        end
    endfunction

endpackage

### rtl/sine_tone_synthesizer.sv
// Top level of the direct digital synthesis sine tone source.
//
//  channel  | dir | tdata bits (low first)                     | tuser
//  ---------+-----+--------------------------------------------+------------------
//  s_axis   | in  | [15:0] tone_freq_hz, [31:16] tone_level    | [1:0] req_type
//  m_axis   | out | [7:0] density (signed)                     | -
//
// Ticks: one per cycle while s_axis_tready is high; the sine RAM is read on the accepting
// edge into stage 1, and the scaled density then moves on into the output register (m_axis_tvalid).
// Set tone: the input stays closed after the transfer while the step unit works (reciprocal
// multiply, sum, remainder check). Tone off: no stall.
// Reset: a fill pass writes all 256 sine RAM entries; no input is taken meanwhile.
// A stalled output holds two ticks (stage 1 and output register), then s_axis_tready drops.
module sine_tone_synthesizer #(
    parameter int FS_HZ = stsyn_pkg::DEF_FS_HZ
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [stsyn_pkg::S_TDATA_W-1:0] s_axis_tdata,  // tone_freq_hz, tone_level
    input  logic [stsyn_pkg::REQ_W-1:0]     s_axis_tuser,  // req_type
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [stsyn_pkg::M_TDATA_W-1:0] m_axis_tdata   // density
);

    localparam int AW = stsyn_pkg::TABLE_AW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(stsyn_pkg::TABLE_DEPTH - 1);

    logic [stsyn_pkg::FREQ_W-1:0]  w_freq;
    logic [stsyn_pkg::LEVEL_W-1:0] w_level;
    logic                          w_xfer;
    logic                          w_tick;
    logic                          w_set;
    logic                          w_off;
    logic                          w_div_busy;
    logic [stsyn_pkg::PHASE_W-1:0] w_step;
    logic [stsyn_pkg::PHASE_W-1:0] n_phase;
    logic [stsyn_pkg::AMP_W-1:0]   w_level_sat;
    logic                          w_out_free;
    logic                          w_s1_adv;
    logic                          w_s1_free;
    logic [7:0]                    w_rdata;
    logic signed [21:0]            w_prod;

    logic                          r_init_busy;
    logic [AW-1:0]                 r_init_addr;
    logic [stsyn_pkg::PHASE_W-1:0] r_phase;
    logic [stsyn_pkg::AMP_W-1:0]   r_amp;
    logic                          r_s1_valid;
    logic [stsyn_pkg::AMP_W-1:0]   r_s1_amp;
    logic                          r_out_valid;
    logic [stsyn_pkg::DENS_W-1:0]  r_out_data;

    // Input decode
    assign w_freq  = s_axis_tdata[stsyn_pkg::FREQ_W-1:0];
    assign w_level = s_axis_tdata[stsyn_pkg::S_TDATA_W-1:stsyn_pkg::FREQ_W];
    assign w_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_tick  = w_xfer && (s_axis_tuser == stsyn_pkg::REQ_TICK);
    assign w_set   = w_xfer && (s_axis_tuser == stsyn_pkg::REQ_SET);
    assign w_off   = w_xfer && (s_axis_tuser == stsyn_pkg::REQ_OFF);

    // Pipeline flow control
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_s1_adv      = r_s1_valid && w_out_free;
    assign w_s1_free     = !r_s1_valid || w_out_free;
    assign s_axis_tready = !r_init_busy && !w_div_busy && w_s1_free;

    // Phase step unit
    stsyn_step_div #(
        .FS_HZ(FS_HZ)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_set),
        .i_freq (w_freq),
        .o_busy (w_div_busy),
        .o_step (w_step)
    );

    // Sine RAM: filled after reset, read at the top phase bits on a tick
    stsyn_ram #(
        .WIDTH(8),
        .DEPTH(stsyn_pkg::TABLE_DEPTH)
    ) u_sine_ram (
        .i_clk  (i_clk),
        .i_we   (r_init_busy),
        .i_waddr(r_init_addr),
        .i_wdata(stsyn_pkg::sine_value(r_init_addr)),
        .i_re   (w_tick),
        .i_raddr(n_phase[stsyn_pkg::INDEX_SHIFT +: AW]),
        .o_rdata(w_rdata)
    );

    // Fill pass sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_busy <= 1'b1;
            r_init_addr <= '0;
        end else if (r_init_busy) begin
            r_init_addr <= r_init_addr + 1'b1;
            if (r_init_addr == LAST_ADDR) begin
                r_init_busy <= 1'b0;
            end
        end
    end

    // Phase accumulator and amplitude
    assign n_phase     = r_phase + w_step;
    assign w_level_sat = (w_level > stsyn_pkg::LEVEL_W'(stsyn_pkg::AMP_MAX))
                         ? stsyn_pkg::AMP_MAX : w_level[stsyn_pkg::AMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_amp   <= '0;
        end else begin
            if (w_tick) begin
                r_phase <= n_phase;
            end
            if (w_set) begin
                r_amp <= w_level_sat;
            end else if (w_off) begin
                r_amp <= '0;
            end
        end
    end

    // Stage 1: RAM data returns; amplitude travels alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_tick) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_s1_amp <= r_amp;
        end
    end

    // Scale and floor-shift into the output register
    assign w_prod = $signed(w_rdata) * $signed({1'b0, r_s1_amp});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_data <= w_prod[stsyn_pkg::AMP_SHIFT +: stsyn_pkg::DENS_W];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### rtl/stsyn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module stsyn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/stsyn_step_div.sv
// Phase step unit: step = floor(freq * 2^32 / sample rate) mod 2^32 by reciprocal multiply.
module stsyn_step_div #(
    parameter int FS_HZ = stsyn_pkg::DEF_FS_HZ
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [stsyn_pkg::FREQ_W-1:0]  i_freq,
    output logic                          o_busy,
    output logic [stsyn_pkg::PHASE_W-1:0] o_step
);

    // Reciprocal floor(2^48 / fs) in two 20-bit halves; the estimate
    // floor(freq * recip / 2^16) is the exact quotient or one below it
    localparam int SUM_W   = stsyn_pkg::FREQ_W + stsyn_pkg::PHASE_W;
    localparam int KW      = 20;
    localparam int RECIP_W = 2 * KW;
    localparam int PROD_W  = stsyn_pkg::FREQ_W + KW;
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'd1 << SUM_W) / 64'(FS_HZ));
    localparam logic [KW-1:0]      RECIP_LO = RECIP[KW-1:0];
    localparam logic [KW-1:0]      RECIP_HI = RECIP[RECIP_W-1:KW];

    // Remainder of the estimate lies in [0, 2*fs), so its low REM_W bits suffice
    localparam int               REM_W   = $clog2(FS_HZ) + 1;
    localparam logic [REM_W-1:0] DIVISOR = REM_W'(FS_HZ);

    logic                          r_v1;
    logic                          r_v2;
    logic                          r_v3;
    logic [PROD_W-1:0]             r_prod_lo;
    logic [PROD_W-1:0]             r_prod_hi;
    logic [stsyn_pkg::PHASE_W-1:0] r_q0;
    logic [stsyn_pkg::PHASE_W-1:0] r_q1;
    logic [REM_W-1:0]              r_low;
    logic [stsyn_pkg::PHASE_W-1:0] r_step;

    logic [SUM_W-1:0]              w_sum;
    logic [REM_W-1:0]              w_rem;
    logic                          w_ge;

    // Recombine the partial products; only the low 48 bits feed the step
    assign w_sum = {r_prod_hi[SUM_W-KW-1:0], {KW{1'b0}}}
                 + {{(SUM_W-PROD_W){1'b0}}, r_prod_lo};

    // freq * 2^32 is 0 mod 2^REM_W, so the remainder is -q0 * fs there
    assign w_rem = -r_low;
    assign w_ge  = (w_rem >= DIVISOR);

    // Stage valids and the step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_step <= '0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v3) begin
                r_step <= r_q1 + {{(stsyn_pkg::PHASE_W-1){1'b0}}, w_ge};
            end
        end
    end

    // Datapath: constant multiplies, estimate, remainder product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod_lo <= PROD_W'(i_freq) * PROD_W'(RECIP_LO);
            r_prod_hi <= PROD_W'(i_freq) * PROD_W'(RECIP_HI);
        end
        if (r_v1) begin
            r_q0 <= w_sum[SUM_W-1:stsyn_pkg::FREQ_W];
        end
        if (r_v2) begin
            r_low <= r_q0[REM_W-1:0] * DIVISOR;
            r_q1  <= r_q0;
        end
    end

    assign o_busy = r_v1 || r_v2 || r_v3;
    assign o_step = r_step;

endmodule

### rtl/stsyn_checker.sv
// Port-level assertions for the tone synthesizer, bound to the top level.
module stsyn_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [stsyn_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic [stsyn_pkg::REQ_W-1:0]     s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [stsyn_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // Density never reaches the most negative code
    a_dens_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata != 8'h80)
        else $error("density out of range");

    // The divider interlock closes the input right after a set-tone transfer
    a_set_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == stsyn_pkg::REQ_SET)
        |=> !s_axis_tready)
        else $error("input open during step division");

    // The sine RAM fill pass keeps the input closed after reset
    a_fill_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input open during sine RAM fill");

endmodule

bind sine_tone_synthesizer stsyn_checker u_stsyn_checker (.*);

### test/density_checker.sv
// Stream monitor for the tone synthesizer: predicts each density and checks the output stream.
module density_checker #(
    parameter int FS_HZ = stsyn_pkg::DEF_FS_HZ
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [stsyn_pkg::S_TDATA_W-1:0] i_s_tdata,  // tone_freq_hz, tone_level
    input  logic [stsyn_pkg::REQ_W-1:0]     i_s_tuser,  // req_type
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [stsyn_pkg::M_TDATA_W-1:0] i_m_tdata,  // density
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked
);
    import stsyn_pkg::*;

    // Rising quarter of the wave, peak included
    localparam logic [6:0] RISE_QUARTER [0:64] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,
        7'd24,  7'd27,  7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,
        7'd48,  7'd51,  7'd54,  7'd57,  7'd59,  7'd62,  7'd65,  7'd67,
        7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd82,  7'd85,  7'd87,
        7'd89,  7'd91,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd103,
        7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116,
        7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123,
        7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
        7'd127
    };

    logic signed [7:0]        wave [0:TABLE_DEPTH-1];
    logic [PHASE_W-1:0]       tone_phase;
    logic [PHASE_W-1:0]       tone_step;
    logic [AMP_W-1:0]         cur_amp;
    logic [DENS_W-1:0]        density_q [$];
    int                       err_cnt;
    int                       checked_cnt;

    // Full signed wave: mirrored within each half, negated in the upper half
    initial begin : build_wave
        int k;
        int mag;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            k   = n % 128;
            mag = (k <= 64) ? int'(RISE_QUARTER[k]) : int'(RISE_QUARTER[128 - k]);
            wave[n] = (n >= 128) ? 8'(-mag) : 8'(mag);
        end
    end

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("density_checker: %s (t=%0t)", msg, $realtime);
    endtask

    // Input transfers update the tone state; output transfers are checked in order
    always @(posedge i_clk) begin : track
        logic [47:0]       quot;
        int                prod;
        logic [DENS_W-1:0] want;
        if (!i_rst_n) begin
            tone_phase = '0;
            tone_step  = '0;
            cur_amp    = '0;
            density_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    REQ_TICK: begin
                        tone_phase = tone_phase + tone_step;
                        prod = int'(wave[tone_phase[PHASE_W-1 -: TABLE_AW]]) * int'(cur_amp);
                        prod = prod >>> AMP_SHIFT;
                        density_q.push_back(prod[DENS_W-1:0]);
                    end
                    REQ_SET: begin
                        quot      = {i_s_tdata[FREQ_W-1:0], 32'd0} / 48'(FS_HZ);
                        tone_step = quot[PHASE_W-1:0];
                        if (i_s_tdata[S_TDATA_W-1:FREQ_W] > 16'(AMP_MAX)) begin
                            cur_amp = AMP_MAX;
                        end else begin
                            cur_amp = i_s_tdata[FREQ_W +: AMP_W];
                        end
                    end
                    REQ_OFF: begin
                        cur_amp = '0;
                    end
                    default: begin
                        // undefined request: no effect
                    end
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (density_q.size() == 0) begin
                    report_mismatch($sformatf("density %0d with no tick pending",
                                              $signed(i_m_tdata)));
                end else begin
                    want = density_q.pop_front();
                    checked_cnt++;
                    if (i_m_tdata !== want) begin
                        report_mismatch($sformatf("density got %0d want %0d",
                                                  $signed(i_m_tdata), $signed(want)));
                    end
                end
            end
        end
        o_pending <= density_q.size();
        o_errors  <= err_cnt;
        o_checked <= checked_cnt;
    end

endmodule

### test/tb_top.sv
// Top of the tone synthesizer testbench: clock, reset, request stimulus, output backpressure.
module tb_top;
    import stsyn_pkg::*;

    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
    localparam int RANDOM_ITEMS = 1075;
    localparam int CALM_ITEMS   = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 250000;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata   = '0;  // [15:0] tone_freq_hz, [31:16] tone_level
    logic [REQ_W-1:0]     s_axis_tuser   = '0;  // [1:0] req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // [7:0] density

    logic quiet    = 1'b0;
    logic hold_req = 1'b0;
    int   cycles   = 0;
    int   n_ticks  = 0;
    int   n_sets   = 0;
    int   n_offs   = 0;
    int   n_undef  = 0;
    int   errors;
    int   pending;
    int   checked;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sine_tone_synthesizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    density_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Output backpressure: random stall bursts, one long hold-off, steady at the end
    initial begin : sink
        bit held;
        held = 1'b0;
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // One request transfer, with an optional idle burst ahead of it
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [FREQ_W-1:0] freq,
                                input logic [LEVEL_W-1:0] level);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {level, freq};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        case (kind)
            REQ_TICK: n_ticks++;
            REQ_SET:  n_sets++;
            REQ_OFF:  n_offs++;
            default:  n_undef++;
        endcase
    endtask

    initial begin : stimulus
        int               pick;
        logic [REQ_W-1:0] kind;
        logic [FREQ_W-1:0]  freq;
        logic [LEVEL_W-1:0] level;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset state, quarter-turn step at the amplitude extremes
        send_request(REQ_TICK, 16'd0, 16'd0);
        send_request(REQ_TICK, 16'hFFFF, 16'hFFFF);   // operands ignored on a tick
        send_request(REQ_SET, 16'd8000, 16'd4096);
        repeat (4) send_request(REQ_TICK, 16'd0, 16'd0);
        send_request(REQ_SET, 16'd8000, 16'd4095);    // negative peak rounds down
        repeat (4) send_request(REQ_TICK, 16'd0, 16'd0);
        send_request(REQ_SET, 16'd8000, 16'd1);
        repeat (3) send_request(REQ_TICK, 16'd0, 16'd0);
        send_request(REQ_SET, 16'hFFFF, 16'hFFFF);    // step wraps, level saturates
        repeat (2) send_request(REQ_TICK, 16'd0, 16'd0);
        send_request(REQ_OFF, 16'hFFFF, 16'hFFFF);    // silence, phase still moves
        send_request(REQ_TICK, 16'd0, 16'd0);
        send_request(REQ_RESERVED, 16'hABCD, 16'h1234);
        send_request(REQ_TICK, 16'h5555, 16'hAAAA);
        send_request(REQ_SET, 16'd0, 16'd0);
        send_request(REQ_TICK, 16'd0, 16'd0);

        // Random: tone changes with runs of ticks between them
        hold_req <= 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - CALM_ITEMS) quiet <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 70)      kind = REQ_TICK;
            else if (pick < 85) kind = REQ_SET;
            else if (pick < 95) kind = REQ_OFF;
            else                kind = REQ_RESERVED;
            case ($urandom_range(0, 3))
                0:       freq = 16'($urandom_range(0, 65535));
                1:       freq = 16'($urandom_range(0, 4000));
                2:       freq = 16'(8000 * $urandom_range(0, 8));
                default: freq = 16'(65535 - $urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 3))
                0:       level = 16'($urandom_range(0, 65535));
                1:       level = 16'($urandom_range(0, 4096));
                2:       level = 16'(4095 + $urandom_range(0, 2));
                default: level = 16'($urandom_range(0, 63));
            endcase
            send_request(kind, freq, level);
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give the pipeline time to show any extra output
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);

        $display("tb_top: %0d ticks, %0d tone sets, %0d tone offs, %0d undefined requests",
                 n_ticks, n_sets, n_offs, n_undef);
        $display("tb_top: %0d densities compared, %0d mismatches, %0d-cycle output hold-off",
                 checked, errors, HOLD_CYCLES);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
